>>> src/qpv_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and the sequencer state type of the quadrature decoder.
package qpv_pkg;

   // Payload widths.
   localparam int unsigned POS_W = 32;
   localparam int unsigned VEL_W = 32;
   localparam int unsigned NUM_W = 48;
   localparam int unsigned TICK_W = 32;

   // Configuration port.
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PER_EDGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_NUMERATOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd3;

   // Register values after reset.
   localparam logic [POS_W-1:0] STEP_PER_EDGE_RESET = 32'd236794;
   localparam logic [NUM_W-1:0] VELOCITY_NUMERATOR_RESET = 48'd236794000000;
   localparam logic [VEL_W-1:0] OUTLIER_LIMIT_RESET = 32'd644245094;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 32'd100000;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

endpackage

>>> src/qpv_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the request, result and configuration channels.
interface qpv_req_if;
   logic valid;
   logic ready;
   logic line_a;
   logic line_b;

   modport source (output valid, output line_a, output line_b, input ready);
   modport sink (input valid, input line_a, input line_b, output ready);
endinterface

interface qpv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [qpv_pkg::POS_W-1:0]  position;
   logic [qpv_pkg::VEL_W-1:0]  velocity;
   logic                       direction;
   logic                       stopped;

   modport source (output valid, output position, output velocity, output direction,
                   output stopped, input ready);
   modport sink (input valid, input position, input velocity, input direction,
                 input stopped, output ready);
endinterface

interface qpv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [qpv_pkg::CSR_IDX_W-1:0]   index;
   logic [qpv_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/quadrature_position_velocity_top.sv
`timescale 1ns / 1ps
// Quadrature decoder with position, period-based velocity, averaging and stop report.
//
//   channel  direction  payload                                   role
//   req_bus  in         line_a, line_b                            one line sample per tick
//   rsp_bus  out        position, velocity, direction, stopped    edge or stop report
//   csr_bus  in         index (2 bits), data (48 bits)            register write, always ready
//
// A sample without an edge stays in IDLE; a stop report goes through EMIT to load the output.
// A sample with an edge passes DIVIDE, CHECK and EMIT; the shared restoring divider gives one
// quotient bit per cycle. When the averaging buffer completes, the same divider then forms the
// mean in a second DIVIDE pass before EMIT.
// Reset is synchronous; there is no clearing pass.
// A finished result waits in the output register; new requests are taken while it waits,
// but the next result is not loaded until the previous one has been taken.
module quadrature_position_velocity_top #(
   parameter int unsigned AVERAGE_DEPTH = 5
) (
   input logic         clock,
   input logic         reset,
   qpv_req_if.sink     req_bus,
   qpv_rsp_if.source   rsp_bus,
   qpv_csr_if.sink     csr_bus
);

   localparam int unsigned POS_W = qpv_pkg::POS_W;
   localparam int unsigned VEL_W = qpv_pkg::VEL_W;
   localparam int unsigned NUM_W = qpv_pkg::NUM_W;
   localparam int unsigned TICK_W = qpv_pkg::TICK_W;
   localparam int unsigned FILL_W = $clog2(AVERAGE_DEPTH);
   localparam int unsigned SUM_W = VEL_W + FILL_W;
   localparam int unsigned STEP_W = $clog2(NUM_W + 1);

   // Configuration registers.
   logic [POS_W-1:0]  step_ff, step_in;
   logic [NUM_W-1:0]  vnum_ff, vnum_in;
   logic [VEL_W-1:0]  limit_ff, limit_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;

   // Decoder state.
   qpv_pkg::state_type state_ff, state_in;
   logic              prev_a_ff, prev_a_in;
   logic              prev_b_ff, prev_b_in;
   logic [POS_W-1:0]  angle_ff, angle_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              dir_ff, dir_in;
   logic              timed_out_ff, timed_out_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [VEL_W-1:0]  held_ff, held_in;
   logic              stop_ff, stop_in;
   logic              mean_phase_ff, mean_phase_in;

   // Shared divider.
   logic [VEL_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [VEL_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [VEL_W-1:0]  out_vel_ff, out_vel_in;
   logic              out_dir_ff, out_dir_in;
   logic              out_stop_ff, out_stop_in;

   logic              req_take;
   logic [TICK_W-1:0] ticks_inc;
   logic              line_edge;
   logic              fwd;
   logic [VEL_W:0]    rem_shift;
   logic [VEL_W:0]    rem_diff;
   logic              fits;
   logic [VEL_W-1:0]  rem_next;
   logic [NUM_W-1:0]  quo_next;
   logic              speed_ok;
   logic [SUM_W-1:0]  sum_add;

   assign req_bus.ready = (state_ff == qpv_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.position = out_pos_ff;
   assign rsp_bus.velocity = out_vel_ff;
   assign rsp_bus.direction = out_dir_ff;
   assign rsp_bus.stopped = out_stop_ff;

   // Tick count saturates, and an edge is any change on either line.
   assign ticks_inc = (ticks_ff == {TICK_W{1'b1}}) ? ticks_ff : ticks_ff + 1'b1;
   assign line_edge = (req_bus.line_a != prev_a_ff) || (req_bus.line_b != prev_b_ff);
   assign fwd = ~(prev_a_ff ^ req_bus.line_b);

   // One restoring division step: shift in the next dividend bit and subtract if it fits.
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff = rem_shift - {1'b0, dvs_ff};
   assign fits = (rem_shift >= {1'b0, dvs_ff});
   assign rem_next = fits ? rem_diff[VEL_W-1:0] : rem_shift[VEL_W-1:0];
   assign quo_next = {quo_ff[NUM_W-2:0], fits};

   // The quotient is compared at its full width with the outlier limit.
   assign speed_ok = (quo_ff[NUM_W-1:VEL_W] == '0) && (quo_ff[VEL_W-1:0] <= limit_ff);
   assign sum_add = sum_ff + {{FILL_W{1'b0}}, quo_ff[VEL_W-1:0]};

   // Configuration writes.
   always_comb begin
      step_in = step_ff;
      vnum_in = vnum_ff;
      limit_in = limit_ff;
      timeout_in = timeout_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            qpv_pkg::CSR_STEP_PER_EDGE: step_in = csr_bus.data[POS_W-1:0];
            qpv_pkg::CSR_VELOCITY_NUMERATOR: vnum_in = csr_bus.data[NUM_W-1:0];
            qpv_pkg::CSR_OUTLIER_LIMIT: limit_in = csr_bus.data[VEL_W-1:0];
            qpv_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_bus.data[TICK_W-1:0];
         endcase
      end
   end

   // Sequencer: edge and timeout test, speed division, outlier check, mean division, result load.
   always_comb begin
      state_in = state_ff;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      angle_in = angle_ff;
      ticks_in = ticks_ff;
      dir_in = dir_ff;
      timed_out_in = timed_out_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      held_in = held_ff;
      stop_in = stop_ff;
      mean_phase_in = mean_phase_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      out_valid_in = out_valid_ff;
      out_pos_in = out_pos_ff;
      out_vel_in = out_vel_ff;
      out_dir_in = out_dir_ff;
      out_stop_in = out_stop_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         qpv_pkg::ST_IDLE: begin
            if (req_take) begin
               prev_a_in = req_bus.line_a;
               prev_b_in = req_bus.line_b;
               if (line_edge) begin
                  dir_in = fwd;
                  angle_in = fwd ? angle_ff + step_ff : angle_ff - step_ff;
                  ticks_in = '0;
                  timed_out_in = 1'b0;
                  stop_in = 1'b0;
                  rem_in = '0;
                  quo_in = vnum_ff;
                  dvs_in = ticks_inc;
                  cnt_in = STEP_W'(NUM_W);
                  mean_phase_in = 1'b0;
                  state_in = qpv_pkg::ST_DIVIDE;
               end else begin
                  ticks_in = ticks_inc;
                  if ((ticks_inc > timeout_ff) && !timed_out_ff) begin
                     timed_out_in = 1'b1;
                     stop_in = 1'b1;
                     state_in = qpv_pkg::ST_EMIT;
                  end
               end
            end
         end
         qpv_pkg::ST_DIVIDE: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               if (mean_phase_ff) begin
                  held_in = quo_next[VEL_W-1:0];
                  state_in = qpv_pkg::ST_EMIT;
               end else begin
                  state_in = qpv_pkg::ST_CHECK;
               end
            end
         end
         qpv_pkg::ST_CHECK: begin
            state_in = qpv_pkg::ST_EMIT;
            if (speed_ok) begin
               if (fill_ff == FILL_W'(AVERAGE_DEPTH - 1)) begin
                  // Buffer complete: divide the running sum by the depth.
                  fill_in = '0;
                  sum_in = '0;
                  rem_in = '0;
                  quo_in = {sum_add, {(NUM_W - SUM_W){1'b0}}};
                  dvs_in = VEL_W'(AVERAGE_DEPTH);
                  cnt_in = STEP_W'(SUM_W);
                  mean_phase_in = 1'b1;
                  state_in = qpv_pkg::ST_DIVIDE;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  sum_in = sum_add;
               end
            end
         end
         qpv_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_pos_in = angle_ff;
               out_vel_in = stop_ff ? '0 : held_ff;
               out_dir_in = dir_ff;
               out_stop_in = stop_ff;
               state_in = qpv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qpv_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= qpv_pkg::STEP_PER_EDGE_RESET;
         vnum_ff <= qpv_pkg::VELOCITY_NUMERATOR_RESET;
         limit_ff <= qpv_pkg::OUTLIER_LIMIT_RESET;
         timeout_ff <= qpv_pkg::TIMEOUT_TICKS_RESET;
         state_ff <= qpv_pkg::ST_IDLE;
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         angle_ff <= '0;
         ticks_ff <= '0;
         dir_ff <= 1'b1;
         timed_out_ff <= 1'b0;
         fill_ff <= '0;
         sum_ff <= '0;
         held_ff <= '0;
         stop_ff <= 1'b0;
         mean_phase_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         vnum_ff <= vnum_in;
         limit_ff <= limit_in;
         timeout_ff <= timeout_in;
         state_ff <= state_in;
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         angle_ff <= angle_in;
         ticks_ff <= ticks_in;
         dir_ff <= dir_in;
         timed_out_ff <= timed_out_in;
         fill_ff <= fill_in;
         sum_ff <= sum_in;
         held_ff <= held_in;
         stop_ff <= stop_in;
         mean_phase_ff <= mean_phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Divider and output payload registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      out_dir_ff <= out_dir_in;
      out_stop_ff <= out_stop_in;
   end

endmodule

>>> src/qpv_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the quadrature decoder, bound to its top level.
module qpv_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [qpv_pkg::POS_W-1:0]  rsp_position,
   input logic [qpv_pkg::VEL_W-1:0]  rsp_velocity,
   input logic                       rsp_direction,
   input logic                       rsp_stopped
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position)
         && $stable(rsp_velocity) && $stable(rsp_direction) && $stable(rsp_stopped)))
      else $error("result payload changed while stalled");

   // A stop report always carries zero velocity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stopped) |-> (rsp_velocity == '0))
      else $error("stop report with non-zero velocity");

   // A new result is only loaded while requests are held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while requests were being taken");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A request is never taken in the cycle that loads a result.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("request taken in the cycle a result was loaded");

endmodule

bind quadrature_position_velocity_top qpv_checker u_qpv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_position  (rsp_bus.position),
   .rsp_velocity  (rsp_bus.velocity),
   .rsp_direction (rsp_bus.direction),
   .rsp_stopped   (rsp_bus.stopped)
);
